@@ sv/snc_pkg.sv @@
// package with status codes, register indexes and character class helper for the name checker
`timescale 1ns / 1ps

package snc_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX          = 8'd255;
  localparam logic [CFG_W-1:0]   MAX_NAME_RESET     = 8'd253;
  localparam logic [CFG_W-1:0]   MAX_LABEL_RESET    = 8'd63;

  localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;

  typedef enum logic [0:0] {
    REG_MAX_NAME  = 1'b0,
    REG_MAX_LABEL = 1'b1
  } cfg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 4'd0,
    ST_EMPTY      = 4'd1,
    ST_BAD_CHAR   = 4'd2,
    ST_STAR_PLACE = 4'd3,
    ST_STAR_MANY  = 4'd4,
    ST_TOO_LONG   = 4'd5,
    ST_LABEL_LONG = 4'd6,
    ST_NO_DOT     = 4'd7,
    ST_DOUBLE_DOT = 4'd8
  } status_t;

  function automatic logic char_ok(input logic [CHAR_W-1:0] c);
    logic upper;
    logic lower;
    logic digit;
    upper = (c >= 8'h41) && (c <= 8'h5A);
    lower = (c >= 8'h61) && (c <= 8'h7A);
    digit = (c >= 8'h30) && (c <= 8'h39);
    return upper || lower || digit || (c == CHAR_DASH) || (c == CHAR_DOT) ||
           (c == CHAR_STAR);
  endfunction

endpackage

@@ sv/server_name_checker_core.sv @@
// host name checker: per-character tracking and end-of-name status
`timescale 1ns / 1ps

// Usage
//   in_*  : one name character per transfer; in_tdata holds the byte, in_tuser
//           is the char-present flag (items with it low are not counted), in_tlast
//           closes the name.
//   out_* : one status transfer per closed name; out_tdata holds status in
//           bits 3:0 and the offending character in bits 11:4.
//   cfg_* : write port for the two length limits; write only while the block idles (not enforced).
// Throughput: one character per cycle while no closing item waits on a held result
//   register, set by the single update stage between the input register and the result register.
// Path: a closing transfer passes the input register and then the result register,
//   which offers the status transfer.
// Reset: limits return to 253 and 63, all name state and both valid flags clear.
// Stall: while a result waits and out_tready is low the result register holds; the input register
//   keeps taking characters until it holds a closing item that cannot yet
//   deliver, then in_tready drops.
module server_name_checker_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // name_char[7:0]
  input  logic [snc_pkg::IN_DATA_W-1:0]      in_tdata,
  // char_present[0]
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // status[3:0], offending_char[11:4], zero fill[15:12]
  output logic [snc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [snc_pkg::CFG_W-1:0]          cfg_wdata
);

  import snc_pkg::*;

  logic [CFG_W-1:0]   max_name_r;
  logic [CFG_W-1:0]   max_label_r;

  logic               s1_valid_r;
  logic [CHAR_W-1:0]  s1_char_r;
  logic               s1_present_r;
  logic               s1_last_r;

  logic [COUNT_W-1:0] name_count_r, name_count_nxt;
  logic [COUNT_W-1:0] label_count_r, label_count_nxt;
  logic               label_overflow_r, label_overflow_nxt;
  logic               seen_dot_r, seen_dot_nxt;
  logic               prev_dot_r, prev_dot_nxt;
  logic               double_dot_r, double_dot_nxt;
  logic               star_seen_r, star_seen_nxt;
  logic               star_misplaced_r, star_misplaced_nxt;
  logic               star_repeated_r, star_repeated_nxt;
  logic               bad_valid_r, bad_valid_nxt;
  logic [CHAR_W-1:0]  bad_char_r, bad_char_nxt;

  logic               out_valid_r;
  status_t            out_status_r, status_nxt;
  logic [CHAR_W-1:0]  out_offend_r, offend_nxt;

  logic               out_free;
  logic               s1_adv;
  logic               is_dot;
  logic               is_star;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - STATUS_W - CHAR_W){1'b0}}, out_offend_r, out_status_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_name_r  <= MAX_NAME_RESET;
      max_label_r <= MAX_LABEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_MAX_NAME:  max_name_r  <= cfg_wdata;
        REG_MAX_LABEL: max_label_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r    <= in_tdata[CHAR_W-1:0];
      s1_present_r <= in_tuser;
      s1_last_r    <= in_tlast;
    end
  end

  assign is_dot  = s1_char_r == CHAR_DOT;
  assign is_star = s1_char_r == CHAR_STAR;

  always_comb begin
    name_count_nxt     = name_count_r;
    label_count_nxt    = label_count_r;
    label_overflow_nxt = label_overflow_r;
    seen_dot_nxt       = seen_dot_r;
    prev_dot_nxt       = prev_dot_r;
    double_dot_nxt     = double_dot_r;
    star_seen_nxt      = star_seen_r;
    star_misplaced_nxt = star_misplaced_r;
    star_repeated_nxt  = star_repeated_r;
    bad_valid_nxt      = bad_valid_r;
    bad_char_nxt       = bad_char_r;

    if (s1_present_r) begin
      if (!char_ok(s1_char_r) && !bad_valid_r) begin
        bad_valid_nxt = 1'b1;
        bad_char_nxt  = s1_char_r;
      end
      if (is_star) begin
        if (star_seen_r) begin
          star_repeated_nxt = 1'b1;
        end else if (name_count_r != '0) begin
          star_misplaced_nxt = 1'b1;
        end
        star_seen_nxt = 1'b1;
      end
      if (is_dot) begin
        if (prev_dot_r) begin
          double_dot_nxt = 1'b1;
        end
        if (label_count_r > max_label_r) begin
          label_overflow_nxt = 1'b1;
        end
        label_count_nxt = '0;
        seen_dot_nxt    = 1'b1;
        prev_dot_nxt    = 1'b1;
      end else begin
        if (label_count_r != COUNT_MAX) begin
          label_count_nxt = label_count_r + 1'b1;
        end
        prev_dot_nxt = 1'b0;
      end
      if (name_count_r != COUNT_MAX) begin
        name_count_nxt = name_count_r + 1'b1;
      end
    end

    offend_nxt = '0;
    if (name_count_nxt == '0) begin
      status_nxt = ST_EMPTY;
    end else if (bad_valid_nxt) begin
      status_nxt = ST_BAD_CHAR;
      offend_nxt = bad_char_nxt;
    end else if (star_misplaced_nxt) begin
      status_nxt = ST_STAR_PLACE;
    end else if (star_repeated_nxt) begin
      status_nxt = ST_STAR_MANY;
    end else if (name_count_nxt > max_name_r) begin
      status_nxt = ST_TOO_LONG;
    end else if (label_overflow_nxt || (label_count_nxt > max_label_r)) begin
      status_nxt = ST_LABEL_LONG;
    end else if (!seen_dot_nxt) begin
      status_nxt = ST_NO_DOT;
    end else if (double_dot_nxt) begin
      status_nxt = ST_DOUBLE_DOT;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_adv && s1_last_r)) begin
      name_count_r     <= '0;
      label_count_r    <= '0;
      label_overflow_r <= 1'b0;
      seen_dot_r       <= 1'b0;
      prev_dot_r       <= 1'b0;
      double_dot_r     <= 1'b0;
      star_seen_r      <= 1'b0;
      star_misplaced_r <= 1'b0;
      star_repeated_r  <= 1'b0;
      bad_valid_r      <= 1'b0;
      bad_char_r       <= '0;
    end else if (s1_adv) begin
      name_count_r     <= name_count_nxt;
      label_count_r    <= label_count_nxt;
      label_overflow_r <= label_overflow_nxt;
      seen_dot_r       <= seen_dot_nxt;
      prev_dot_r       <= prev_dot_nxt;
      double_dot_r     <= double_dot_nxt;
      star_seen_r      <= star_seen_nxt;
      star_misplaced_r <= star_misplaced_nxt;
      star_repeated_r  <= star_repeated_nxt;
      bad_valid_r      <= bad_valid_nxt;
      bad_char_r       <= bad_char_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && s1_last_r) begin
      out_status_r <= status_nxt;
      out_offend_r <= offend_nxt;
    end
  end

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the host name checker core
`timescale 1ns / 1ps

module testbench;
  import snc_pkg::*;

  typedef struct packed {
    status_t     st;
    logic [7:0]  off;
  } verdict_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_index_t  idx;
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic        pinned;
    status_t     st;
    logic [7:0]  off;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  in_tlast;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  server_name_checker_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // limits and per-name tracking
  logic [7:0] lim_name;
  logic [7:0] lim_label;
  logic [7:0] name_len;
  logic [7:0] label_len;
  logic       label_over;
  logic       dot_seen;
  logic       prev_dot;
  logic       dbl_dot;
  logic       star_seen;
  logic       star_misplaced;
  logic       star_repeated;
  logic       bad_valid;
  logic [7:0] bad_char;

  verdict_t   verdict_q[$];
  verdict_t   fresh;
  verdict_t   want;
  verdict_t   pin_verdict;
  bit         pin_on;
  bit         calm_in;
  bit         calm_out;

  int         in_xfers;
  int         out_xfers;
  int         fails;
  int         items_sent;
  int         settings;
  int         status_seen[9];

  logic [7:0] name_buf[$];
  row_t       plan[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic bit legal_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
           c == CHAR_DASH || c == CHAR_DOT || c == CHAR_STAR;
  endfunction

  task automatic clear_tracking();
    name_len       = '0;
    label_len      = '0;
    label_over     = 1'b0;
    dot_seen       = 1'b0;
    prev_dot       = 1'b0;
    dbl_dot        = 1'b0;
    star_seen      = 1'b0;
    star_misplaced = 1'b0;
    star_repeated  = 1'b0;
    bad_valid      = 1'b0;
    bad_char       = '0;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    if (!legal_char(c) && !bad_valid) begin
      bad_valid = 1'b1;
      bad_char  = c;
    end
    if (c == CHAR_STAR) begin
      if (star_seen) star_repeated = 1'b1;
      else if (name_len != 0) star_misplaced = 1'b1;
      star_seen = 1'b1;
    end
    if (c == CHAR_DOT) begin
      if (prev_dot) dbl_dot = 1'b1;
      if (label_len > lim_label) label_over = 1'b1;
      label_len = '0;
      dot_seen  = 1'b1;
      prev_dot  = 1'b1;
    end else begin
      if (label_len != COUNT_MAX) label_len = label_len + 8'd1;
      prev_dot = 1'b0;
    end
    if (name_len != COUNT_MAX) name_len = name_len + 8'd1;
  endtask

  function automatic verdict_t name_verdict();
    verdict_t v;
    v.off = '0;
    if (name_len == 0) v.st = ST_EMPTY;
    else if (bad_valid) begin
      v.st  = ST_BAD_CHAR;
      v.off = bad_char;
    end
    else if (star_misplaced) v.st = ST_STAR_PLACE;
    else if (star_repeated) v.st = ST_STAR_MANY;
    else if (name_len > lim_name) v.st = ST_TOO_LONG;
    else if (label_over || label_len > lim_label) v.st = ST_LABEL_LONG;
    else if (!dot_seen) v.st = ST_NO_DOT;
    else if (dbl_dot) v.st = ST_DOUBLE_DOT;
    else v.st = ST_OK;
    return v;
  endfunction

  // input side: every accepted character updates the prediction, every closing transfer queues a verdict
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      in_xfers++;
      if (in_tuser) absorb_char(in_tdata);
      if (in_tlast) begin
        fresh = pin_on ? pin_verdict : name_verdict();
        verdict_q.push_back(fresh);
        clear_tracking();
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      out_xfers++;
      if (out_tdata[3:0] < 9) status_seen[out_tdata[3:0]]++;
      if (verdict_q.size() == 0) begin
        $error("unexpected result transfer: status %0d", out_tdata[3:0]);
        fails++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[3:0] !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_tdata[3:0]);
          fails++;
        end
        if (out_tdata[11:4] !== want.off) begin
          $error("offending_char: expected 0x%02h, got 0x%02h", want.off, out_tdata[11:4]);
          fails++;
        end
      end
    end
  end

  initial begin : ready_gen
    int stall;
    int target;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      target = out_xfers + 1;
      do @(negedge clk); while (out_xfers < target);
    end
  end

  task automatic drive(input logic [7:0] c, input logic p, input logic l);
    int gap;
    int target;
    gap = calm_in ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= c;
    in_tuser  <= p;
    in_tlast  <= l;
    in_tvalid <= 1'b1;
    target = in_xfers + 1;
    do @(negedge clk); while (in_xfers < target);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_limit(input cfg_index_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_NAME) lim_name = val;
    else lim_label = val;
    @(negedge clk);
  endtask

  function automatic row_t it(input logic [7:0] c, input logic p, input logic l);
    row_t r;
    r = '0;
    r.kind    = ROW_ITEM;
    r.data    = c;
    r.present = p;
    r.last    = l;
    return r;
  endfunction

  function automatic row_t endp(input logic [7:0] c, input logic p, input status_t st,
                                input logic [7:0] off);
    row_t r;
    r = it(c, p, 1'b1);
    r.pinned = 1'b1;
    r.st     = st;
    r.off    = off;
    return r;
  endfunction

  function automatic row_t wr(input cfg_index_t idx, input logic [7:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = val;
    return r;
  endfunction

  function automatic logic [7:0] host_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return CHAR_DASH;
  endfunction

  function automatic logic [7:0] pick_limit(input int lo);
    case ($urandom_range(0, 5))
      0: return 8'd1;
      1: return 8'd254;
      2: return 8'($urandom_range(1, lo));
      default: return 8'($urandom_range(lo, 4 * lo));
    endcase
  endfunction

  task automatic long_name(input int total);
    int i;
    name_buf.delete();
    for (i = 0; i < total; i++)
      name_buf.push_back((i % 101 == 100) ? CHAR_DOT : 8'("a" + i % 26));
  endtask

  task automatic build_name();
    int mode;
    int labels;
    int len;
    int i;
    int j;
    int pos;
    name_buf.delete();
    mode = $urandom_range(0, 15);
    if (mode == 1) begin
      len = $urandom_range(1, 12);
      for (i = 0; i < len; i++) name_buf.push_back(8'($urandom_range(0, 255)));
    end else if (mode != 0) begin
      if ($urandom_range(0, 5) == 0) begin
        name_buf.push_back(CHAR_STAR);
        name_buf.push_back(CHAR_DOT);
      end
      labels = $urandom_range(1, 4);
      for (i = 0; i < labels; i++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
        for (j = 0; j < len; j++) name_buf.push_back(host_char());
        if (i != labels - 1) name_buf.push_back(CHAR_DOT);
      end
      // broken variants
      if (mode <= 5) begin
        pos = $urandom_range(0, name_buf.size());
        case ($urandom_range(0, 5))
          0: begin
            if (name_buf.size() == 0) name_buf.push_back(8'($urandom_range(0, 255)));
            else name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(0, 255));
          end
          1: name_buf.insert(pos, CHAR_STAR);
          2: begin
            name_buf.insert(pos, CHAR_DOT);
            name_buf.insert(pos, CHAR_DOT);
          end
          3: name_buf.push_front(CHAR_DOT);
          4: name_buf.push_back(CHAR_DOT);
          default: name_buf.insert(pos, 8'($urandom_range(128, 255)));
        endcase
      end
    end
  endtask

  task automatic send_name();
    bit absent_close;
    int i;
    absent_close = (name_buf.size() == 0) || ($urandom_range(0, 7) == 0);
    for (i = 0; i < name_buf.size(); i++) begin
      if ($urandom_range(0, 19) == 0) drive(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      drive(name_buf[i], 1'b1, !absent_close && i == name_buf.size() - 1);
      items_sent++;
    end
    if (absent_close) begin
      drive(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  initial begin : stimulus
    int k;
    int n;
    int phase;
    logic [7:0] nl;
    logic [7:0] ll;
    rst_n     = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    in_tvalid = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_MAX_NAME;
    cfg_wdata = '0;
    lim_name  = MAX_NAME_RESET;
    lim_label = MAX_LABEL_RESET;
    pin_on    = 1'b0;
    calm_in   = 1'b0;
    calm_out  = 1'b0;
    clear_tracking();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed names and limit writes
    plan.push_back(endp(8'h00, 1'b0, ST_EMPTY, 8'h00));
    plan.push_back(it("a", 1'b1, 1'b0));
    plan.push_back(it(CHAR_DOT, 1'b1, 1'b0));
    plan.push_back(endp("b", 1'b1, ST_OK, 8'h00));
    plan.push_back(endp(8'hFF, 1'b1, ST_BAD_CHAR, 8'hFF));
    plan.push_back(endp(8'h80, 1'b1, ST_BAD_CHAR, 8'h80));
    plan.push_back(it("a", 1'b1, 1'b0));
    plan.push_back(endp(CHAR_STAR, 1'b1, ST_STAR_PLACE, 8'h00));
    plan.push_back(it(CHAR_STAR, 1'b1, 1'b0));
    plan.push_back(endp(CHAR_STAR, 1'b1, ST_STAR_MANY, 8'h00));
    plan.push_back(endp(CHAR_DASH, 1'b1, ST_NO_DOT, 8'h00));
    plan.push_back(it(CHAR_DOT, 1'b1, 1'b0));
    plan.push_back(endp(CHAR_DOT, 1'b1, ST_DOUBLE_DOT, 8'h00));
    plan.push_back(it("Z", 1'b1, 1'b0));
    plan.push_back(it(CHAR_DOT, 1'b1, 1'b0));
    plan.push_back(it(8'h5C, 1'b0, 1'b0));
    plan.push_back(it("9", 1'b1, 1'b0));
    plan.push_back(endp(8'h00, 1'b0, ST_OK, 8'h00));
    plan.push_back(it(CHAR_STAR, 1'b1, 1'b0));
    plan.push_back(it(CHAR_DOT, 1'b1, 1'b0));
    plan.push_back(it("a", 1'b1, 1'b1));
    plan.push_back(wr(REG_MAX_NAME, 8'd1));
    plan.push_back(it("a", 1'b1, 1'b0));
    plan.push_back(endp(CHAR_DOT, 1'b1, ST_TOO_LONG, 8'h00));
    plan.push_back(wr(REG_MAX_NAME, 8'd254));
    plan.push_back(wr(REG_MAX_LABEL, 8'd1));
    plan.push_back(it("a", 1'b1, 1'b0));
    plan.push_back(it("b", 1'b1, 1'b0));
    plan.push_back(endp(CHAR_DOT, 1'b1, ST_LABEL_LONG, 8'h00));

    for (k = 0; k < plan.size(); k++) begin
      if (plan[k].kind == ROW_CFG) begin
        drain();
        set_limit(plan[k].idx, plan[k].data);
        settings++;
      end else begin
        pin_on      = plan[k].pinned;
        pin_verdict = '{st: plan[k].st, off: plan[k].off};
        drive(plan[k].data, plan[k].present, plan[k].last);
        pin_on = 1'b0;
        if (plan[k].present || plan[k].last) items_sent++;
      end
    end

    // random names, limits changed between batches
    phase = 0;
    while (items_sent < 1750) begin
      drain();
      case (phase)
        0: begin
          nl = 8'd254;
          ll = 8'd254;
        end
        1: begin
          nl = 8'd1;
          ll = 8'd1;
        end
        default: begin
          nl = pick_limit(20);
          ll = pick_limit(4);
        end
      endcase
      set_limit(REG_MAX_NAME, nl);
      set_limit(REG_MAX_LABEL, ll);
      settings++;
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        long_name(254);
        send_name();
        long_name(256);
        send_name();
      end
      for (n = 0; n < 24 && items_sent < 1750; n++) begin
        build_name();
        send_name();
      end
      phase++;
    end

    drain();
    repeat (8) @(negedge clk);
    $display("covered %0d name transfers, %0d input items, %0d limit settings",
             out_xfers, items_sent, settings);
    $display("results by status 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5], status_seen[6], status_seen[7], status_seen[8]);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
